@@ design/grp_pkg.sv @@
// Package: shared types, constants and codes of the rectangle packer.
`timescale 1ns / 1ps
package grp_pkg;
    localparam int MAX_FREE_RECTS_DEF = 64;
    localparam int COORD_W   = 13;
    localparam int RECT_W    = 4 * COORD_W;
    localparam logic [COORD_W-1:0] RESET_ATLAS = 13'd2048;
    localparam logic [COORD_W-1:0] ATLAS_MIN   = 13'd4;
    localparam logic [COORD_W-1:0] ATLAS_MAX   = 13'd4096;
    localparam logic [COORD_W-1:0] PAD         = 13'd2;

    localparam logic OP_PLACE   = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // RAM write data selects.
    localparam logic [1:0] WR_SEL_ATLAS = 2'd0;
    localparam logic [1:0] WR_SEL_ADD0  = 2'd1;
    localparam logic [1:0] WR_SEL_ADD1  = 2'd2;
    localparam logic [1:0] WR_SEL_SHIFT = 2'd3;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic        op;
        logic [11:0] sprite_width;
        logic [11:0] sprite_height;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] placed_x;
        logic [11:0] placed_y;
    } rsp_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } rect_t;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load_req;    // capture request and padded sizes
        logic scan_init;   // clear best-fit tracker
        logic scan_eval;   // evaluate read data of the current scan entry
        logic split;       // compute remainders from the chosen rect
        logic wr_en;       // write ram
        logic [1:0] wr_sel; // one of the WR_SEL_* selects
        logic cnt_set_one;
        logic cnt_add_new;
        logic cnt_dec;
    } dp_cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic       found;
        logic       exact;
        logic [1:0] n_new;
        logic       full;
    } dp_sts_t;
endpackage

@@ design/guillotine_rect_packer_unit.sv @@
// Top level of the guillotine rectangle packer: controller plus datapath.
//
// Channel   | Signals                     | Transfer
// ----------+-----------------------------+-----------------------------------
// request   | start, busy, req            | edge with start high, busy low
// result    | result_valid, rsp           | one cycle strobe, always taken
// config    | atlas_size_we, atlas_size_wdata | edge with atlas_size_we high
//
// A restart rewrites entry zero and sets the count to one. A place request scans
// the list through the single RAM read port; on success a compaction pass
// removes the chosen entry.
// Reset leaves one free rect of the whole 2048 atlas; the RAM entry is written
// by the init logic right after reset, which overrides the controller. busy is high from
// the transfer until the result strobe; the result side never stalls.
`timescale 1ns / 1ps
module guillotine_rect_packer_unit #(
    parameter int MAX_FREE_RECTS = grp_pkg::MAX_FREE_RECTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  grp_pkg::req_t               req,
    output logic                        result_valid,
    output grp_pkg::rsp_t               rsp,
    input  logic                        atlas_size_we,
    input  logic [grp_pkg::COORD_W-1:0] atlas_size_wdata
);
    import grp_pkg::*;
    localparam int AW = $clog2(MAX_FREE_RECTS);
    localparam int CW = $clog2(MAX_FREE_RECTS + 1);

    logic [COORD_W-1:0] atlas_size_reg;
    logic               init_reg;    // load the reset atlas into entry zero
    dp_cmd_t            cmd, ctrl_cmd;
    dp_sts_t            sts;
    logic [AW-1:0]      rd_addr, wr_addr, scan_idx, sel;
    logic [CW-1:0]      count;
    rect_t              chosen;
    logic               done, done_pos, ctrl_busy;
    status_t            done_status;
    logic [COORD_W-1:0] dp_atlas;

    // Hold the atlas size register; reset value matches the reset atlas.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_size_reg <= RESET_ATLAS;
            init_reg       <= 1'b1;
        end
        else
        begin
            if (atlas_size_we)
                atlas_size_reg <= atlas_size_wdata;
            init_reg <= 1'b0;
        end
    end

    // During the init cycle write the reset atlas into entry zero.
    always_comb
    begin
        cmd = ctrl_cmd;
        if (init_reg)
        begin
            cmd        = '0;
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SEL_ATLAS;
        end
    end
    assign dp_atlas = init_reg ? RESET_ATLAS : atlas_size_reg;

    grp_ctrl #(.MAX_FREE_RECTS(MAX_FREE_RECTS)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start & ~init_reg),
        .op          (req.op),
        .busy        (ctrl_busy),
        .cmd         (ctrl_cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .scan_idx    (scan_idx),
        .sts         (sts),
        .sel         (sel),
        .count       (count),
        .done        (done),
        .done_status (done_status),
        .done_pos    (done_pos)
    );

    grp_datapath #(.MAX_FREE_RECTS(MAX_FREE_RECTS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .atlas_size (dp_atlas),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .wr_addr    (init_reg ? '0 : wr_addr),
        .scan_idx   (scan_idx),
        .sts        (sts),
        .sel        (sel),
        .count      (count),
        .chosen     (chosen)
    );

    assign busy         = ctrl_busy | init_reg;
    assign result_valid = done;
    assign rsp.status   = done_status;
    assign rsp.placed_x = done_pos ? chosen.x[11:0] : 12'd0;
    assign rsp.placed_y = done_pos ? chosen.y[11:0] : 12'd0;
endmodule

@@ design/grp_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
module grp_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ design/grp_datapath.sv @@
// Datapath: free-rect RAM, best-fit tracker, split logic and count.
`timescale 1ns / 1ps
module grp_datapath #(
    parameter int MAX_FREE_RECTS = grp_pkg::MAX_FREE_RECTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  grp_pkg::req_t                      req,
    input  logic [grp_pkg::COORD_W-1:0]        atlas_size,
    input  grp_pkg::dp_cmd_t                   cmd,
    input  logic [$clog2(MAX_FREE_RECTS)-1:0]  rd_addr,
    input  logic [$clog2(MAX_FREE_RECTS)-1:0]  wr_addr,
    input  logic [$clog2(MAX_FREE_RECTS)-1:0]  scan_idx,
    output grp_pkg::dp_sts_t                   sts,
    output logic [$clog2(MAX_FREE_RECTS)-1:0]  sel,
    output logic [$clog2(MAX_FREE_RECTS+1)-1:0] count,
    output grp_pkg::rect_t                     chosen
);
    import grp_pkg::*;
    localparam int AW = $clog2(MAX_FREE_RECTS);
    localparam int CW = $clog2(MAX_FREE_RECTS + 1);

    logic [COORD_W-1:0] pw_reg, ph_reg;
    logic               found_reg;
    logic [COORD_W-1:0] sx_reg, sy_reg;
    logic [AW-1:0]      sel_reg;
    rect_t              chosen_reg;
    rect_t              add0_reg, add1_reg;
    logic [1:0]         n_new_reg;
    logic [CW-1:0]      count_reg;
    rect_t              rd_rect;
    logic [RECT_W-1:0]  rd_raw;
    rect_t              wr_rect;
    logic [COORD_W-1:0] side;

    grp_ram #(.WIDTH(RECT_W), .DEPTH(MAX_FREE_RECTS)) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rect),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );
    assign rd_rect = rect_t'(rd_raw);

    always_comb
    begin
        side = atlas_size;
        if (side < ATLAS_MIN) side = ATLAS_MIN;
        if (side > ATLAS_MAX) side = ATLAS_MAX;
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_SEL_ATLAS: wr_rect = '{x: '0, y: '0, w: side, h: side};
            WR_SEL_ADD0:  wr_rect = add0_reg;
            WR_SEL_ADD1:  wr_rect = add1_reg;
            default:      wr_rect = rd_rect;
        endcase
    end

    // Best-fit evaluation of one entry.
    logic               fits, exact_hit, better;
    logic [COORD_W-1:0] dx, dy;
    always_comb
    begin
        dx        = rd_rect.w - pw_reg;
        dy        = rd_rect.h - ph_reg;
        exact_hit = (rd_rect.w == pw_reg) && (rd_rect.h == ph_reg);
        fits      = (rd_rect.w >= pw_reg) && (rd_rect.h >= ph_reg);
        better    = !found_reg || dx < sx_reg || dy < sy_reg;
    end

    logic exact_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            exact_reg <= 1'b0;
            count_reg <= CW'(1);
        end
        else
        begin
            if (cmd.scan_init)
            begin
                found_reg <= 1'b0;
                exact_reg <= 1'b0;
            end
            else if (cmd.scan_eval && !exact_reg)
            begin
                if (exact_hit)
                begin
                    found_reg <= 1'b1;
                    exact_reg <= 1'b1;
                end
                else if (fits && better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.cnt_set_one)
                count_reg <= CW'(1);
            else if (cmd.cnt_add_new)
                count_reg <= count_reg + CW'(n_new_reg);
            else if (cmd.cnt_dec)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            pw_reg <= COORD_W'(req.sprite_width) + PAD;
            ph_reg <= COORD_W'(req.sprite_height) + PAD;
        end
        if (cmd.scan_eval && !exact_reg && (exact_hit || (fits && better)))
        begin
            sel_reg    <= scan_idx;
            chosen_reg <= rd_rect;
            sx_reg     <= exact_hit ? '0 : dx;
            sy_reg     <= exact_hit ? '0 : dy;
        end
        if (cmd.split)
        begin
            n_new_reg <= 2'd0;
            if (!(sx_reg == '0 && sy_reg == '0))
            begin
                if (sx_reg > sy_reg)
                begin
                    add0_reg  <= '{x: chosen_reg.x + pw_reg, y: chosen_reg.y,
                                   w: sx_reg, h: chosen_reg.h};
                    add1_reg  <= '{x: chosen_reg.x, y: chosen_reg.y + ph_reg,
                                   w: pw_reg, h: sy_reg};
                    n_new_reg <= (sy_reg != '0) ? 2'd2 : 2'd1;
                end
                else
                begin
                    add0_reg  <= '{x: chosen_reg.x, y: chosen_reg.y + ph_reg,
                                   w: chosen_reg.w, h: sy_reg};
                    add1_reg  <= '{x: chosen_reg.x + pw_reg, y: chosen_reg.y,
                                   w: sx_reg, h: ph_reg};
                    n_new_reg <= (sx_reg != '0) ? 2'd2 : 2'd1;
                end
            end
        end
    end

    assign sts.found = found_reg;
    assign sts.exact = exact_reg;
    assign sts.n_new = n_new_reg;
    assign sts.full  = ({1'b0, count_reg} + (CW+1)'(n_new_reg)) > (CW+1)'(MAX_FREE_RECTS);
    assign sel    = sel_reg;
    assign count  = count_reg;
    assign chosen = chosen_reg;
endmodule

@@ design/grp_ctrl.sv @@
// Controller: sequences restart, scan, split, append and compaction.
`timescale 1ns / 1ps
module grp_ctrl #(
    parameter int MAX_FREE_RECTS = grp_pkg::MAX_FREE_RECTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                op,
    output logic                                busy,
    output grp_pkg::dp_cmd_t                    cmd,
    output logic [$clog2(MAX_FREE_RECTS)-1:0]   rd_addr,
    output logic [$clog2(MAX_FREE_RECTS)-1:0]   wr_addr,
    output logic [$clog2(MAX_FREE_RECTS)-1:0]   scan_idx,
    input  grp_pkg::dp_sts_t                    sts,
    input  logic [$clog2(MAX_FREE_RECTS)-1:0]   sel,
    input  logic [$clog2(MAX_FREE_RECTS+1)-1:0] count,
    output logic                                done,
    output grp_pkg::status_t                    done_status,
    output logic                                done_pos
);
    import grp_pkg::*;
    localparam int AW = $clog2(MAX_FREE_RECTS);
    localparam int CW = $clog2(MAX_FREE_RECTS + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_LAST  = 9'b000000100,
        S_SPLIT = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_ADD0  = 9'b000100000,
        S_ADD1  = 9'b001000000,
        S_SHIFT = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;   // read pointer
    logic          vld_reg, vld_next;   // read data belongs to idx_reg-1
    logic [CW-1:0] base_reg;            // count before append
    status_t       st_reg, st_next;
    logic          pos_reg, pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            vld_reg   <= 1'b0;
            st_reg    <= ST_OK;
            pos_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            vld_reg   <= vld_next;
            st_reg    <= st_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHECK)
            base_reg <= count;
    end

    logic [CW-1:0] idx_m1;
    assign idx_m1   = idx_reg - CW'(1);
    assign scan_idx = idx_m1[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        vld_next   = 1'b0;
        st_next    = st_reg;
        pos_next   = pos_reg;
        cmd        = '0;
        rd_addr    = idx_reg[AW-1:0];
        wr_addr    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_RESTART)
                    begin
                        cmd.wr_en       = 1'b1;
                        cmd.wr_sel      = WR_SEL_ATLAS;
                        cmd.cnt_set_one = 1'b1;
                        st_next    = ST_OK;
                        pos_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.load_req = 1'b1;
                        cmd.scan_init = 1'b1;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue read of idx_reg; evaluate data from previous read.
                cmd.scan_eval = vld_reg;
                if (idx_reg < count && idx_reg < CW'(MAX_FREE_RECTS))
                begin
                    idx_next = idx_reg + CW'(1);
                    vld_next = 1'b1;
                end
                else
                    state_next = S_LAST;
            end
            S_LAST:
            begin
                if (!sts.found)
                begin
                    st_next = ST_NO_FIT; pos_next = 1'b0; state_next = S_DONE;
                end
                else
                begin
                    cmd.split = 1'b1; state_next = S_SPLIT;
                end
            end
            S_SPLIT:
                state_next = S_CHECK;
            S_CHECK:
            begin
                if (sts.full)
                begin
                    st_next = ST_FULL; pos_next = 1'b0; state_next = S_DONE;
                end
                else
                    state_next = (sts.n_new != 2'd0) ? S_ADD0 : S_SHIFT;
                idx_next = {1'b0, sel} + CW'(1);
            end
            S_ADD0:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SEL_ADD0;
                wr_addr    = base_reg[AW-1:0];
                state_next = (sts.n_new == 2'd2) ? S_ADD1 : S_SHIFT;
                if (sts.n_new != 2'd2) cmd.cnt_add_new = 1'b1;
            end
            S_ADD1:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SEL_ADD1;
                wr_addr    = AW'(base_reg + CW'(1));
                cmd.cnt_add_new = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                // Copy entry idx-1 into idx-2 once its read data is back.
                if (vld_reg)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_SEL_SHIFT;
                    wr_addr    = AW'(idx_reg - CW'(2));
                end
                if (idx_reg < count)
                begin
                    idx_next = idx_reg + CW'(1);
                    vld_next = 1'b1;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    st_next  = ST_OK;
                    pos_next = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_DONE);
    assign done_status = st_reg;
    assign done_pos    = pos_reg;
endmodule

@@ design/grp_checker.sv @@
// Port-level checker for the rectangle packer, bound to the top level.
`timescale 1ns / 1ps
module grp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          result_valid,
    input grp_pkg::rsp_t rsp
);
    import grp_pkg::*;

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy)
        else $error("busy after result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (rsp.status == ST_OK || rsp.status == ST_NO_FIT
                          || rsp.status == ST_FULL))
        else $error("bad status");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && rsp.status != ST_OK) |->
        (rsp.placed_x == 12'd0 && rsp.placed_y == 12'd0))
        else $error("nonzero position on failure");
endmodule

bind guillotine_rect_packer_unit grp_checker u_grp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .rsp          (rsp)
);

@@ sim/testbench.sv @@
// Testbench of the guillotine rectangle packer: directed and random checks against a predictor.
`timescale 1ns / 1ps
module testbench;
    import grp_pkg::*;

    localparam int NUM_RECTS  = MAX_FREE_RECTS_DEF;
    localparam int IDLE_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic result_valid;
    rsp_t rsp;
    logic atlas_size_we;
    logic [COORD_W-1:0] atlas_size_wdata;

    // Predictor state: free list, its fill level and the atlas register.
    rect_t free_list [NUM_RECTS];
    int unsigned free_cnt;
    logic [COORD_W-1:0] atlas_reg;

    rsp_t placements_due [$];
    int unsigned fail_cnt;
    int unsigned idle_cycles;

    guillotine_rect_packer_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req              (req),
        .result_valid     (result_valid),
        .rsp              (rsp),
        .atlas_size_we    (atlas_size_we),
        .atlas_size_wdata (atlas_size_wdata)
    );

    always #4 clk = ~clk;

    // Reload the free list with one rect covering the whole atlas.
    function automatic void load_atlas(int unsigned side);
        for (int i = 0; i < NUM_RECTS; i++)
            free_list[i] = '0;
        free_list[0].w = side[COORD_W-1:0];
        free_list[0].h = side[COORD_W-1:0];
        free_cnt = 1;
    endfunction

    // Work out the answer to one request and advance the free list.
    function automatic rsp_t predict_packing(req_t r);
        rsp_t        res;
        int unsigned pw, ph, side, sel, sx, sy, nw, nh, n_new;
        bit          found;
        rect_t       c;
        rect_t       add [2];
        res = '0;
        found = 0;
        sel = 0;
        sx = 0;
        sy = 0;
        n_new = 0;
        pw = r.sprite_width + 2;
        ph = r.sprite_height + 2;
        if (r.op == OP_RESTART) begin
            side = atlas_reg;
            if (side < ATLAS_MIN) side = ATLAS_MIN;
            if (side > ATLAS_MAX) side = ATLAS_MAX;
            load_atlas(side);
            res.status = ST_OK;
            return res;
        end
        for (int unsigned i = 0; i < free_cnt; i++) begin
            nw = free_list[i].w;
            nh = free_list[i].h;
            if (nw == pw && nh == ph) begin
                found = 1;
                sel = i;
                sx = 0;
                sy = 0;
                break;
            end
            if (nw >= pw && nh >= ph) begin
                if (!found || (nw - pw) < sx || (nh - ph) < sy) begin
                    found = 1;
                    sel = i;
                    sx = nw - pw;
                    sy = nh - ph;
                end
            end
        end
        if (!found) begin
            res.status = ST_NO_FIT;
            return res;
        end
        c = free_list[sel];
        // Split along the larger slack; an exact fit leaves no remainder.
        if (!(sx == 0 && sy == 0)) begin
            if (sx > sy) begin
                add[n_new] = '{x: COORD_W'(c.x + pw), y: c.y, w: COORD_W'(sx), h: c.h};
                n_new++;
                if (sy > 0) begin
                    add[n_new] = '{x: c.x, y: COORD_W'(c.y + ph), w: COORD_W'(pw),
                                   h: COORD_W'(sy)};
                    n_new++;
                end
            end
            else begin
                add[n_new] = '{x: c.x, y: COORD_W'(c.y + ph), w: c.w, h: COORD_W'(sy)};
                n_new++;
                if (sx > 0) begin
                    add[n_new] = '{x: COORD_W'(c.x + pw), y: c.y, w: COORD_W'(sx),
                                   h: COORD_W'(ph)};
                    n_new++;
                end
            end
        end
        if (free_cnt + n_new > NUM_RECTS) begin
            res.status = ST_FULL;
            return res;
        end
        for (int unsigned i = 0; i < n_new; i++)
            free_list[free_cnt + i] = add[i];
        free_cnt += n_new;
        for (int unsigned i = sel; i + 1 < free_cnt; i++)
            free_list[i] = free_list[i + 1];
        free_cnt--;
        free_list[free_cnt] = '0;
        res.status = ST_OK;
        res.placed_x = c.x[11:0];
        res.placed_y = c.y[11:0];
        return res;
    endfunction

    // Present one request and hold it until the transfer; start stays high.
    task automatic send_request(logic op, int unsigned sw, int unsigned sh);
        req_t r;
        rsp_t due;
        r.op = op;
        r.sprite_width = sw[11:0];
        r.sprite_height = sh[11:0];
        req <= r;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        due = predict_packing(r);
        placements_due = {placements_due, due};
    endtask

    task automatic hold_off(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drain all results, then write the atlas register while idle.
    task automatic write_atlas(int unsigned side);
        hold_off(1);
        while (placements_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        atlas_size_we <= 1'b1;
        atlas_size_wdata <= side[COORD_W-1:0];
        @(posedge clk);
        atlas_size_we <= 1'b0;
        atlas_reg = side[COORD_W-1:0];
    endtask

    // Random bursts of requests; restart_pct restarts, big_pct full-range sizes.
    task automatic send_burst_mix(int unsigned items, int unsigned restart_pct,
                                  int unsigned big_pct, int unsigned max_small,
                                  bit gaps);
        int unsigned burst;
        burst = $urandom_range(1, 8);
        for (int unsigned n = 0; n < items; n++) begin
            if ($urandom_range(99) < restart_pct)
                send_request(OP_RESTART, $urandom, $urandom);
            else if ($urandom_range(99) < big_pct)
                send_request(OP_PLACE, $urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                send_request(OP_PLACE, $urandom_range(0, max_small),
                             $urandom_range(0, max_small));
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 8);
                if (gaps)
                    hold_off($urandom_range(1, 6));
            end
        end
    endtask

    task automatic test_reset_state();
        // Place into the atlas left by reset, then hit each extreme size.
        send_request(OP_PLACE, 1, 1);
        send_request(OP_PLACE, 0, 0);
        send_request(OP_PLACE, 4094, 4094);
        send_request(OP_PLACE, 2046, 1);
        send_request(OP_PLACE, 4095, 4095);
        hold_off(2);
    endtask

    task automatic test_exact_fit();
        // Whole largest atlas taken by one sprite, then the list is empty.
        write_atlas(4096);
        send_request(OP_RESTART, 0, 0);
        send_request(OP_PLACE, 4094, 4094);
        send_request(OP_PLACE, 0, 0);
        // Smallest atlas: zero size pads to exactly 2x2 four times.
        write_atlas(4);
        send_request(OP_RESTART, 4095, 4095);
        for (int i = 0; i < 5; i++)
            send_request(OP_PLACE, 0, 0);
        hold_off(1);
    endtask

    task automatic test_atlas_saturation();
        // Out-of-range sizes clamp to the legal range on restart.
        write_atlas(0);
        send_request(OP_RESTART, 0, 0);
        send_request(OP_PLACE, 2, 2);
        send_request(OP_PLACE, 0, 0);
        write_atlas(8191);
        send_request(OP_RESTART, 0, 0);
        send_request(OP_PLACE, 4094, 1);
        send_request(OP_PLACE, 4093, 4093);
        hold_off(1);
    endtask

    task automatic test_full_list();
        // Tiny sprites in a large atlas grow the list until it overflows.
        write_atlas(4096);
        send_request(OP_RESTART, 0, 0);
        send_burst_mix(110, 0, 0, 40, 1);
        hold_off(1);
    endtask

    task automatic test_random_phases();
        int unsigned side;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: side = 4096;
                1: side = 4;
                2: side = 2048;
                default: side = $urandom_range(0, 8191);
            endcase
            write_atlas(side);
            send_request(OP_RESTART, 0, 0);
            send_burst_mix(101, 3, 8, (p % 2) ? 60 : 300, p != 3);
            hold_off(1);
        end
    endtask

    // Compare every result strobe with the oldest prediction.
    always @(posedge clk) begin
        rsp_t want;
        if (result_valid) begin
            if (placements_due.size() == 0) begin
                $error("result with nothing pending: status %0d", rsp.status);
                fail_cnt++;
            end
            else begin
                want = placements_due.pop_front();
                if (rsp.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    fail_cnt++;
                end
                if (rsp.placed_x !== want.placed_x) begin
                    $error("placed_x: expected %0d, actual %0d", want.placed_x,
                           rsp.placed_x);
                    fail_cnt++;
                end
                if (rsp.placed_y !== want.placed_y) begin
                    $error("placed_y: expected %0d, actual %0d", want.placed_y,
                           rsp.placed_y);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer or result.
    always @(posedge clk) begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        atlas_size_we = 1'b0;
        atlas_size_wdata = '0;
        fail_cnt = 0;
        idle_cycles = 0;
        atlas_reg = RESET_ATLAS;
        load_atlas(RESET_ATLAS);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_exact_fit();
        test_atlas_saturation();
        test_full_list();
        test_random_phases();

        hold_off(1);
        while (placements_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ files.f @@
design/grp_pkg.sv
design/grp_ram.sv
design/grp_datapath.sv
design/grp_ctrl.sv
design/guillotine_rect_packer_unit.sv
design/grp_checker.sv
sim/testbench.sv
